// ===== hdl/pst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Types, token codes and keyword table for the Pascal subset tokenizer.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int NumWords = 30;
    localparam logic [30:0] ValueMax = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_WORD  = 4'd1,
        MODE_DEC   = 4'd2,
        MODE_OCT   = 4'd3,
        MODE_HEX   = 4'd4,
        MODE_LT    = 4'd5,
        MODE_GT    = 4'd6,
        MODE_COLON = 4'd7
    } t_mode;

    localparam logic [5:0] TK_IDENT  = 6'd30;
    localparam logic [5:0] TK_NUMBER = 6'd31;
    localparam logic [5:0] TK_PUNCT0 = 6'd32;
    localparam logic [5:0] TK_LT     = 6'd43;
    localparam logic [5:0] TK_LE     = 6'd44;
    localparam logic [5:0] TK_NE     = 6'd45;
    localparam logic [5:0] TK_GT     = 6'd46;
    localparam logic [5:0] TK_GE     = 6'd47;
    localparam logic [5:0] TK_COLON  = 6'd48;
    localparam logic [5:0] TK_ASSIGN = 6'd49;
    localparam logic [5:0] TK_END    = 6'd50;
    localparam logic [5:0] TK_UNDEF  = 6'd51;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_char_in;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [30:0] number_value;
        logic        number_overflow;
        logic [63:0] name_text;
        logic [7:0]  name_length;
        logic        last;
    } t_token;

    // keywords, first character in the low byte, zero padded
    function automatic logic [71:0] word_text(input int unsigned k);
        logic [71:0] w;
        w = '0;
        case (k)
            0:  w = {"nigeb"};
            1:  w = {"dne"};
            2:  w = {"tsnoc"};
            3:  w = {"erudecorp"};
            4:  w = {"drawrof"};
            5:  w = {"noitcnuf"};
            6:  w = {"fi"};
            7:  w = {"neht"};
            8:  w = {"esle"};
            9:  w = {"margorp"};
            10: w = {"elihw"};
            11: w = {"tixe"};
            12: w = {"rav"};
            13: w = {"regetni"};
            14: w = {"rof"};
            15: w = {"od"};
            16: w = {"ot"};
            17: w = {"otnwod"};
            18: w = {"yarra"};
            19: w = {"nletirw"};
            20: w = {"nldaer"};
            21: w = {"kaerb"};
            22: w = {"etirw"};
            23: w = {"fo"};
            24: w = {"ro"};
            25: w = {"dom"};
            26: w = {"vid"};
            27: w = {"ton"};
            28: w = {"dna"};
            29: w = {"rox"};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] word_len(input int unsigned k);
        logic [71:0] w;
        logic [3:0]  n;
        w = word_text(k);
        n = '0;
        for (int i = 0; i < 9; i++) begin
            if (w[8*i +: 8] != 8'd0) n = 4'(i + 1);
        end
        return n;
    endfunction

endpackage

// ===== hdl/pst_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface pst_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pst_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_scan
// Scanner state and next-state logic: consumes one character per beat and
// produces up to two tokens.
// ----------------------------------------------------------------------------
module pst_scan
    import pst_pkg::*;
#(
    parameter int NAME_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_char,
    input  logic        i_eoi,
    output logic [1:0]  o_count,
    output t_token      o_tok0,
    output t_token      o_tok1
);

    t_mode            r_mode, n_mode;
    logic [29:0]      r_cand, n_cand;
    logic [63:0]      r_buf, n_buf;
    logic [7:0]       r_cnt, n_cnt;
    logic [30:0]      r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic             r_dig, n_dig;

    logic             is_alpha, is_digit, is_space, is_oct, is_hex;
    logic [3:0]       hex_val;
    logic [35:0]      prod;
    logic [4:0]       base;
    t_token           flush_tok, idle_tok, op_tok;
    logic             flush_has, idle_has, cont, op_hit;
    logic [29:0]      cand_start;
    logic [5:0]       kw_kind;
    logic             kw_hit;

    function automatic t_token mk(input logic [5:0] k);
        t_token t;
        t = '0;
        t.token_kind = k;
        return t;
    endfunction

    // candidate mask after appending char c at position p to mask m
    function automatic logic [29:0] narrow(input logic [29:0] m, input logic [7:0] p,
                                           input logic [7:0] c);
        logic [29:0] r;
        logic [71:0] w;
        r = m;
        for (int k = 0; k < NumWords; k++) begin
            w = word_text(k);
            if (p >= 8'(word_len(k))) r[k] = 1'b0;
            else if (w[8*p[3:0] +: 8] != c) r[k] = 1'b0;
        end
        return r;
    endfunction

    always_comb begin
        is_alpha = (i_char >= "a" && i_char <= "z") || (i_char >= "A" && i_char <= "Z");
        is_digit = i_char >= "0" && i_char <= "9";
        is_space = i_char == " " || (i_char >= 8'd9 && i_char <= 8'd13);
        is_oct   = i_char >= "0" && i_char <= "7";
        hex_val  = i_char[3:0];
        is_hex   = is_digit;
        if (i_char >= "a" && i_char <= "f") begin
            is_hex = 1'b1; hex_val = 4'(i_char - "a" + 8'd10);
        end else if (i_char >= "A" && i_char <= "F") begin
            is_hex = 1'b1; hex_val = 4'(i_char - "A" + 8'd10);
        end
    end

    // keyword priority search on final candidate set
    always_comb begin
        kw_hit  = 1'b0;
        kw_kind = TK_IDENT;
        for (int k = NumWords - 1; k >= 0; k--) begin
            if (r_cand[k] && 8'(word_len(k)) == r_cnt) begin
                kw_hit = 1'b1; kw_kind = 6'(k);
            end
        end
    end

    always_comb begin
        flush_tok = '0;
        flush_has = 1'b1;
        case (r_mode)
            MODE_WORD: begin
                if (kw_hit) flush_tok = mk(kw_kind);
                else begin
                    flush_tok = mk(TK_IDENT);
                    for (int i = 0; i < NAME_CHARS; i++)
                        flush_tok.name_text[8*i +: 8] = r_buf[8*i +: 8];
                    flush_tok.name_length = r_cnt;
                end
            end
            MODE_DEC, MODE_OCT, MODE_HEX: begin
                if (!r_dig) flush_tok = mk(TK_UNDEF);
                else begin
                    flush_tok = mk(TK_NUMBER);
                    flush_tok.number_value    = r_acc;
                    flush_tok.number_overflow = r_ovf;
                end
            end
            MODE_LT:    flush_tok = mk(TK_LT);
            MODE_GT:    flush_tok = mk(TK_GT);
            MODE_COLON: flush_tok = mk(TK_COLON);
            default:    flush_has = 1'b0;
        endcase
    end

    // continuation: character extends the pending token or completes a two-character operator
    always_comb begin
        cont   = 1'b0;
        op_hit = 1'b0;
        op_tok = '0;
        base   = 5'd10;
        case (r_mode)
            MODE_WORD: cont = is_alpha || is_digit;
            MODE_DEC:  cont = is_digit;
            MODE_OCT:  begin cont = is_oct; base = 5'd8; end
            MODE_HEX:  begin cont = is_hex; base = 5'd16; end
            MODE_LT: begin
                if (i_char == "=") begin op_hit = 1'b1; op_tok = mk(TK_LE); end
                else if (i_char == ">") begin op_hit = 1'b1; op_tok = mk(TK_NE); end
            end
            MODE_GT: if (i_char == "=") begin op_hit = 1'b1; op_tok = mk(TK_GE); end
            MODE_COLON: if (i_char == "=") begin op_hit = 1'b1; op_tok = mk(TK_ASSIGN); end
            default: cont = 1'b0;
        endcase
        if (i_eoi) begin cont = 1'b0; op_hit = 1'b0; end
    end

    always_comb begin
        cand_start = '1;
        idle_has   = 1'b1;
        idle_tok   = mk(TK_UNDEF);
        case (i_char)
            "(": idle_tok = mk(TK_PUNCT0);
            ")": idle_tok = mk(TK_PUNCT0 + 6'd1);
            "=": idle_tok = mk(TK_PUNCT0 + 6'd2);
            ",": idle_tok = mk(TK_PUNCT0 + 6'd3);
            ";": idle_tok = mk(TK_PUNCT0 + 6'd4);
            ".": idle_tok = mk(TK_PUNCT0 + 6'd5);
            "+": idle_tok = mk(TK_PUNCT0 + 6'd6);
            "-": idle_tok = mk(TK_PUNCT0 + 6'd7);
            "*": idle_tok = mk(TK_PUNCT0 + 6'd8);
            "[": idle_tok = mk(TK_PUNCT0 + 6'd9);
            "]": idle_tok = mk(TK_PUNCT0 + 6'd10);
            default: idle_tok = mk(TK_UNDEF);
        endcase
        if (is_space || is_alpha || is_digit || i_char == "&" || i_char == "$" ||
            i_char == "<" || i_char == ">" || i_char == ":")
            idle_has = 1'b0;
    end

    // value times base plus digit: shifts for 8/16, shift-add for 10
    always_comb begin
        case (base)
            5'd8:    prod = {5'd0, r_acc} << 3;
            5'd16:   prod = {5'd0, r_acc} << 4;
            default: prod = ({5'd0, r_acc} << 3) + ({5'd0, r_acc} << 1);
        endcase
        prod = prod + 36'((r_mode == MODE_HEX) ? hex_val : i_char[3:0]);
    end

    always_comb begin
        n_mode = r_mode; n_cand = r_cand; n_buf = r_buf; n_cnt = r_cnt;
        n_acc = r_acc; n_ovf = r_ovf; n_dig = r_dig;
        o_count = 2'd0; o_tok0 = '0; o_tok1 = '0;
        if (i_eoi) begin
            n_mode = MODE_IDLE;
            if (flush_has) begin
                o_count = 2'd2; o_tok0 = flush_tok; o_tok1 = mk(TK_END);
            end else begin
                o_count = 2'd1; o_tok0 = mk(TK_END);
            end
        end else if (cont && r_mode == MODE_WORD) begin
            if (r_cnt < 8'(NAME_CHARS)) n_buf[8*r_cnt[2:0] +: 8] = i_char;
            n_cand = narrow(r_cand, r_cnt, i_char);
            if (r_cnt != 8'd255) n_cnt = r_cnt + 8'd1;
        end else if (cont) begin
            n_dig = 1'b1;
            if (prod > 36'(ValueMax)) begin
                n_acc = ValueMax; n_ovf = 1'b1;
            end else n_acc = prod[30:0];
        end else if (op_hit) begin
            n_mode = MODE_IDLE; o_count = 2'd1; o_tok0 = op_tok;
        end else begin
            n_mode = MODE_IDLE;
            if (is_alpha) begin
                n_mode = MODE_WORD;
                n_buf  = '0;
                n_buf[7:0] = i_char;
                n_cnt  = 8'd1;
                n_cand = narrow(cand_start, 8'd0, i_char);
            end else if (is_digit) begin
                n_mode = MODE_DEC; n_acc = {27'd0, i_char[3:0]}; n_ovf = 1'b0; n_dig = 1'b1;
            end else if (i_char == "&" || i_char == "$") begin
                n_mode = (i_char == "&") ? MODE_OCT : MODE_HEX;
                n_acc = '0; n_ovf = 1'b0; n_dig = 1'b0;
            end else if (i_char == "<") n_mode = MODE_LT;
            else if (i_char == ">") n_mode = MODE_GT;
            else if (i_char == ":") n_mode = MODE_COLON;
            if (flush_has && idle_has) begin
                o_count = 2'd2; o_tok0 = flush_tok; o_tok1 = idle_tok;
            end else if (flush_has) begin
                o_count = 2'd1; o_tok0 = flush_tok;
            end else if (idle_has) begin
                o_count = 2'd1; o_tok0 = idle_tok;
            end
        end
        if (o_count == 2'd2) o_tok1.last = 1'b1;
        else if (o_count == 2'd1) o_tok0.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cand <= '1;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_dig  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_cand <= n_cand;
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_dig  <= n_dig;
        end
    end

endmodule

// ===== hdl/pst_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_out_buf
// Two-entry token buffer feeding the result channel one token per beat.
// ----------------------------------------------------------------------------
module pst_out_buf
    import pst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [1:0] i_count,
    input  t_token     i_tok0,
    input  t_token     i_tok1,
    output logic       o_empty_next,
    pst_stream_if.source out_if
);

    logic [1:0] r_cnt, n_cnt;
    t_token     r_t0, r_t1;
    logic       pop;

    assign pop          = out_if.valid && out_if.ready;
    assign out_if.valid = r_cnt != 2'd0;
    assign out_if.data  = r_t0;
    // space for a new pair once the current tail is leaving
    assign o_empty_next = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_comb begin
        n_cnt = r_cnt - {1'b0, pop};
        if (i_load) n_cnt = i_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_load) begin
            r_t0 <= i_tok0;
            r_t1 <= i_tok1;
        end else if (pop) begin
            r_t0 <= r_t1;
        end
    end

endmodule

// ===== hdl/pascal_subset_tokenizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_subset_tokenizer_core
// Streaming tokenizer: ASCII characters in, tokens out.
// ----------------------------------------------------------------------------
// Input channel: one character (or end-of-input mark) per beat.
// Output channel: one token per beat; last marks the final token caused by
// a character. A character yields zero, one or two tokens.
// Scanner state updates as a character is accepted; its tokens land in a
// two-entry output buffer the next cycle.
// Throughput: one character per cycle while the buffer drains in time; after
// a character that yields two tokens, the next waits until both have left,
// so the sustained rate is set by output beats.
// A new character is taken whenever the buffer will be empty after this
// cycle, so a stalled receiver stalls the input as soon as a token waits.
// Reset (synchronous, active low) returns the scanner to idle between
// tokens and empties the buffer.
// ----------------------------------------------------------------------------
module pascal_subset_tokenizer_core
    import pst_pkg::*;
#(
    parameter int NAME_CHARS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pst_stream_if.sink   in_if,
    pst_stream_if.source out_if
);

    logic       step;
    logic       room;
    logic [1:0] count;
    t_token     tok0, tok1;

    assign in_if.ready = room;
    assign step        = in_if.valid && room;

    pst_scan #(.NAME_CHARS(NAME_CHARS)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (in_if.data.char_code),
        .i_eoi   (in_if.data.end_of_input),
        .o_count (count),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    pst_out_buf u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (step),
        .i_count      (count),
        .i_tok0       (tok0),
        .i_tok1       (tok1),
        .o_empty_next (room),
        .out_if       (out_if)
    );

    a_eoi_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && in_if.data.end_of_input |=> out_if.valid)
        else $error("end of input produced no token");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid && out_if.data.token_kind == TK_END |-> out_if.data.last)
        else $error("end token not marked last");
    a_name_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid && out_if.data.token_kind != TK_IDENT |-> out_if.data.name_length == 8'd0)
        else $error("name length on non-identifier");

endmodule
